### src/text_mode_console_writer_assert.svh
// Assertion macros for the text mode console writer.
`ifndef TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_MODE_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define TMCW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tmcw assertion failed");
// Next-cycle implication.
`define TMCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tmcw assertion failed");
`else
`define TMCW_ASSERT_IMPL(label, ante, cons)
`define TMCW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/tmcw_pkg.sv
// Shared types and constants of the text mode console writer.
package tmcw_pkg;

    // Field widths that cover the whole supported screen geometry
    localparam int MAX_ADDR_W = 13;
    localparam int MAX_COL_W  = 7;
    localparam int MAX_ROW_W  = 6;
    localparam int CELL_W     = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Item modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Back end operations
    localparam logic [1:0] OP_MOVE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    // One classified command from the front end
    typedef struct packed {
        logic [1:0]            op;
        logic                  wr;      // write data at addr
        logic                  scroll;  // scroll the screen after the write
        logic                  rd_ok;   // read index in range
        logic [MAX_ADDR_W-1:0] addr;
        logic [CELL_W-1:0]     data;
        logic [MAX_COL_W-1:0]  col;     // cursor after the word
        logic [MAX_ROW_W-1:0]  row;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

### src/text_mode_console_writer.sv
// Top level of the text mode console writer.
//
//  channel  | handshake            | words
//  ---------+----------------------+--------------------------------------------
//  command  | i_start / o_busy     | i_mode i_char_code i_back_color
//           |                      | i_fore_color i_read_index
//  result   | o_done (one cycle)   | o_cursor_column o_cursor_row
//           |                      | o_cursor_pos o_cell_data
//
// After reset the back end sweeps every screen cell to blank, with o_busy high
// throughout. With the back end idle, a put, mode 3 or out-of-range read is
// popped from the queue and its result registered onto o_done; an in-range read
// first passes through ST_READ and the registered read port of the screen memory.
// A clear sweeps every cell to blank before o_done; a put that scrolls first
// copies each row up by one, at one cell a cycle, then blanks the bottom row.
// A two-word queue lets new words in while the back end works; o_busy rises
// when it is full. Results cannot be held off.
module text_mode_console_writer
    import tmcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_back_color,
    input  logic [3:0]  i_fore_color,
    input  logic [10:0] i_read_index,
    output logic        o_done,
    output logic [6:0]  o_cursor_column,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_pos,
    output logic [15:0] o_cell_data
);

`include "text_mode_console_writer_assert.svh"

    logic          accept, push, pop;
    t_cmd          push_cmd, head;
    t_queue_status queue_status;
    t_back_status  back_status;

    assign o_busy = back_status.init_busy || queue_status.full;
    assign accept = i_start && !o_busy;

    tmcw_front #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_back_color (i_back_color),
        .i_fore_color (i_fore_color),
        .i_read_index (i_read_index),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    tmcw_cmd_fifo u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (queue_status)
    );

    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_queue         (queue_status),
        .o_pop           (pop),
        .o_status        (back_status),
        .o_done          (o_done),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_pos    (o_cursor_pos),
        .o_cell_data     (o_cell_data)
    );

    // Reported cursor stays on the screen
    `TMCW_ASSERT_IMPL(a_col_range, o_done, int'(o_cursor_column) < COLUMNS)
    `TMCW_ASSERT_IMPL(a_row_range, o_done, int'(o_cursor_row) < ROWS)
    // The blanking sweep runs once after reset and emits nothing
    `TMCW_ASSERT_NEXT(a_init_once, !back_status.init_busy, !back_status.init_busy)
    `TMCW_ASSERT_IMPL(a_no_result_in_init, back_status.init_busy, !o_done && !pop)

endmodule

### src/tmcw_ram.sv
// Generic single write port RAM with a registered read port.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tmcw_front.sv
// Front end: accepts words, moves the cursor and classifies each word.
module tmcw_front
    import tmcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_back_color,
    input  logic [3:0]  i_fore_color,
    input  logic [10:0] i_read_index,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int COL_TW = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_TW = $clog2(ROWS + 1);
    localparam int PH_W   = $clog2(TAB_STOP);

    // Cursor, plus column modulo the tab stop so tabs need no divider
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PH_W-1:0]  r_phase, n_phase;

    logic [COL_TW-1:0] col_t;
    logic [ROW_TW-1:0] row_t;
    t_cmd              cmd;

    // Cursor movement and command build
    always_comb begin
        col_t      = COL_TW'(r_col);
        row_t      = ROW_TW'(r_row);
        n_phase    = r_phase;
        cmd.op     = OP_MOVE;
        cmd.wr     = 1'b0;
        cmd.scroll = 1'b0;
        cmd.rd_ok  = 1'b0;
        cmd.addr   = MAX_ADDR_W'(r_row) * MAX_ADDR_W'(COLUMNS) + MAX_ADDR_W'(r_col);
        cmd.data   = {i_back_color, i_fore_color, i_char_code};

        unique case (i_mode)
            MODE_PUT: begin
                case (i_char_code)
                    CH_BS: begin
                        if (r_col != '0) begin
                            col_t   = col_t - COL_TW'(1);
                            n_phase = (r_phase == '0) ? PH_W'(TAB_STOP - 1)
                                                      : r_phase - PH_W'(1);
                        end
                    end
                    CH_TAB: begin
                        col_t   = col_t + (COL_TW'(TAB_STOP) - COL_TW'(r_phase));
                        n_phase = '0;
                    end
                    CH_CR: begin
                        col_t   = '0;
                        n_phase = '0;
                    end
                    CH_LF: begin
                        col_t   = '0;
                        n_phase = '0;
                        row_t   = row_t + ROW_TW'(1);
                    end
                    default: begin
                        // printable 0x20..0x7F; high bytes do nothing
                        if (i_char_code >= CH_SPACE && !i_char_code[7]) begin
                            cmd.wr  = 1'b1;
                            col_t   = col_t + COL_TW'(1);
                            n_phase = (r_phase == PH_W'(TAB_STOP - 1)) ? '0
                                                                       : r_phase + PH_W'(1);
                        end
                    end
                endcase
                // wrap past the last column
                if (col_t >= COL_TW'(COLUMNS)) begin
                    col_t   = '0;
                    n_phase = '0;
                    row_t   = row_t + ROW_TW'(1);
                end
                // scroll past the last row
                if (row_t >= ROW_TW'(ROWS)) begin
                    cmd.scroll = 1'b1;
                    row_t      = ROW_TW'(ROWS - 1);
                end
            end
            MODE_CLEAR: begin
                cmd.op  = OP_CLEAR;
                col_t   = '0;
                row_t   = '0;
                n_phase = '0;
            end
            MODE_READ: begin
                cmd.op    = OP_READ;
                cmd.addr  = MAX_ADDR_W'(i_read_index);
                cmd.rd_ok = ((MAX_ADDR_W + 1)'(i_read_index) < (MAX_ADDR_W + 1)'(CELLS));
            end
            default: begin
                cmd.op = OP_MOVE;
            end
        endcase

        n_col   = col_t[COL_W-1:0];
        n_row   = row_t[ROW_W-1:0];
        cmd.col = MAX_COL_W'(n_col);
        cmd.row = MAX_ROW_W'(n_row);
    end

    // Cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
        end
    end

    assign o_push = i_accept;
    assign o_cmd  = cmd;

endmodule

### src/tmcw_cmd_fifo.sv
// Short command queue between the front end and the back end.
module tmcw_cmd_fifo
    import tmcw_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_data,
    input  logic          i_pop,
    output t_cmd          o_head,
    output t_queue_status o_status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd                   r_buf [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0]       r_count;
    logic                   do_push, do_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_buf[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### src/tmcw_back.sv
// Back end: runs commands against the screen memory and emits results.
module tmcw_back
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_head,
    input  t_queue_status i_queue,
    output logic          o_pop,
    output t_back_status  o_status,
    output logic          o_done,
    output logic [6:0]    o_cursor_column,
    output logic [4:0]    o_cursor_row,
    output logic [10:0]   o_cursor_pos,
    output logic [15:0]   o_cell_data
);

    localparam int CELLS       = COLUMNS * ROWS;
    localparam int AW          = $clog2(CELLS);
    localparam int COPY_END    = (ROWS - 1) * COLUMNS - 1;
    localparam int BLANK_START = (ROWS - 1) * COLUMNS;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_waddr_p, n_waddr_p;
    logic          r_pend, n_pend;
    t_cmd          r_cmd, n_cmd;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [CELL_W-1:0]     wdata, rdata;
    logic                  emit;
    logic [MAX_COL_W-1:0]  emit_col;
    logic [MAX_ROW_W-1:0]  emit_row;
    logic [CELL_W-1:0]     emit_cell;
    logic [MAX_ADDR_W-1:0] emit_loc;

    logic                  r_done;
    logic [MAX_COL_W-1:0]  r_col;
    logic [MAX_ROW_W-1:0]  r_row;
    logic [MAX_ADDR_W-1:0] r_loc;
    logic [CELL_W-1:0]     r_cell;

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Sequencer: init sweep, single commands, scroll copy and blank, clear sweep
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_waddr_p = r_waddr_p;
        n_pend    = r_pend;
        n_cmd     = r_cmd;
        we        = 1'b0;
        waddr     = r_idx;
        wdata     = BLANK_CELL;
        re        = 1'b0;
        raddr     = r_idx;
        o_pop     = 1'b0;
        emit      = 1'b0;
        emit_col  = r_cmd.col;
        emit_row  = r_cmd.row;
        emit_cell = '0;

        unique case (r_state)
            ST_INIT: begin
                we    = 1'b1;
                n_idx = r_idx + AW'(1);
                if (r_idx == AW'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_queue.empty) begin
                    o_pop    = 1'b1;
                    n_cmd    = i_head;
                    emit_col = i_head.col;
                    emit_row = i_head.row;
                    unique case (i_head.op)
                        OP_MOVE: begin
                            we    = i_head.wr;
                            waddr = i_head.addr[AW-1:0];
                            wdata = i_head.data;
                            if (i_head.scroll) begin
                                n_idx   = '0;
                                n_pend  = 1'b0;
                                n_state = ST_COPY;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_idx   = '0;
                            n_state = ST_CLEAR;
                        end
                        OP_READ: begin
                            if (i_head.rd_ok) begin
                                re      = 1'b1;
                                raddr   = i_head.addr[AW-1:0];
                                n_state = ST_READ;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                emit      = 1'b1;
                emit_cell = rdata;
                n_state   = ST_IDLE;
            end
            ST_COPY: begin
                // read one row down, write the cell read last cycle
                re        = 1'b1;
                raddr     = r_idx + AW'(COLUMNS);
                we        = r_pend;
                waddr     = r_waddr_p;
                wdata     = rdata;
                n_pend    = 1'b1;
                n_waddr_p = r_idx;
                n_idx     = r_idx + AW'(1);
                if (r_idx == AW'(COPY_END)) begin
                    n_idx   = AW'(BLANK_START);
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                we = 1'b1;
                if (r_pend) begin
                    // last copied cell first
                    waddr  = r_waddr_p;
                    wdata  = rdata;
                    n_pend = 1'b0;
                end else begin
                    n_idx = r_idx + AW'(1);
                    if (r_idx == AW'(CELLS - 1)) begin
                        emit    = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                we    = 1'b1;
                n_idx = r_idx + AW'(1);
                if (r_idx == AW'(CELLS - 1)) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign emit_loc = MAX_ADDR_W'(emit_row) * MAX_ADDR_W'(COLUMNS) + MAX_ADDR_W'(emit_col);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_done  <= emit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_waddr_p <= n_waddr_p;
        if (emit) begin
            r_col  <= emit_col;
            r_row  <= emit_row;
            r_loc  <= emit_loc;
            r_cell <= emit_cell;
        end
    end

    assign o_status.init_busy = (r_state == ST_INIT);
    assign o_done             = r_done;
    assign o_cursor_column    = r_col;
    assign o_cursor_row       = r_row[4:0];
    assign o_cursor_pos       = r_loc[10:0];
    assign o_cell_data        = r_cell;

endmodule
